// ===== sv/rgpg_pkg.sv =====
package rgpg_pkg;

   localparam int MaxDimDefault   = 4096;
   localparam int FracBitsDefault = 16;

   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;

   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH  = 3'd0,
      REG_IMAGE_HEIGHT = 3'd1,
      REG_START_RED    = 3'd2,
      REG_START_GREEN  = 3'd3,
      REG_START_BLUE   = 3'd4,
      REG_END_RED      = 3'd5,
      REG_END_GREEN    = 3'd6,
      REG_END_BLUE     = 3'd7
   } reg_index_type;

endpackage

// ===== sv/rgpg_if.sv =====
interface rgpg_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] pixel_x;
   logic [11:0] pixel_y;
   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface rgpg_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] pixel_word;
   logic [23:0] buffer_index;
   logic        out_of_range;
   modport source (output valid, output pixel_word, output buffer_index,
                   output out_of_range, input ready);
   modport sink   (input valid, input pixel_word, input buffer_index,
                   input out_of_range, output ready);
endinterface

// ===== sv/rgpg_sqrt_cell.sv =====
module rgpg_sqrt_cell
   import rgpg_pkg::*;
#(
   parameter int FracBits = FracBitsDefault,
   parameter int Bit      = 0,
   parameter int D2Width  = 27,
   parameter int TagWidth = 50
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  valid_in,
   input  logic [D2Width-1:0]                    dist2_in,
   input  logic [D2Width-1:0]                    diag2_in,
   input  logic [FracBits:0]                     p_in,
   input  logic [2*(FracBits+1)+D2Width-1:0]     sq_in,
   input  logic [FracBits+1+D2Width-1:0]         lin_in,
   input  logic [TagWidth-1:0]                   tag_in,
   output logic                                  valid_out,
   output logic [D2Width-1:0]                    dist2_out,
   output logic [D2Width-1:0]                    diag2_out,
   output logic [FracBits:0]                     p_out,
   output logic [2*(FracBits+1)+D2Width-1:0]     sq_out,
   output logic [FracBits+1+D2Width-1:0]         lin_out,
   output logic [TagWidth-1:0]                   tag_out
);
   localparam int LW = 2 * (FracBits + 1) + D2Width;
   localparam int TW = FracBits + 1 + D2Width;

   logic                 valid_ff;
   logic [D2Width-1:0]   dist2_ff, diag2_ff;
   logic [FracBits:0]    p_ff, p_in_c, cand;
   logic [LW-1:0]        sq_ff, sq_in_c, sq_cand, rhs;
   logic [TW-1:0]        lin_ff, lin_in_c;
   logic [TagWidth-1:0]  tag_ff;
   logic                 keep;

   // sq tracks p^2 * diag2, lin tracks p * diag2
   always_comb begin
      cand     = p_in | ((FracBits+1)'(1) << Bit);
      sq_cand  = sq_in + (LW'(lin_in) << (Bit + 1)) + (LW'(diag2_in) << (2 * Bit));
      rhs      = LW'(dist2_in) << (2 * FracBits);
      keep     = (sq_cand <= rhs);
      p_in_c   = keep ? cand : p_in;
      sq_in_c  = keep ? sq_cand : sq_in;
      lin_in_c = keep ? (lin_in + (TW'(diag2_in) << Bit)) : lin_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dist2_ff <= dist2_in;
         diag2_ff <= diag2_in;
         p_ff     <= p_in_c;
         sq_ff    <= sq_in_c;
         lin_ff   <= lin_in_c;
         tag_ff   <= tag_in;
      end
   end

   assign valid_out = valid_ff;
   assign dist2_out = dist2_ff;
   assign diag2_out = diag2_ff;
   assign p_out     = p_ff;
   assign sq_out    = sq_ff;
   assign lin_out   = lin_ff;
   assign tag_out   = tag_ff;
endmodule

// ===== sv/radial_gradient_pixel_generator_core.sv =====
// Channel | Dir | Handshake   | Payload
// req     | in  | valid/ready | pixel_x, pixel_y
// rsp     | out | valid/ready | pixel_word, buffer_index, out_of_range
// csr     | in  | APB         | eight registers at 4*i
// One transaction per cycle sustained while rsp is taken; the pipeline is an input
// stage, a chain of FracBits + 1 search cells, then blend and output stages.
// The whole pipeline stalls together when rsp is not taken.
// Synchronous reset clears valid flags and loads register reset values.
module radial_gradient_pixel_generator_core
   import rgpg_pkg::*;
#(
   parameter int MaxDim   = MaxDimDefault,
   parameter int FracBits = FracBitsDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   rgpg_req_if.sink                 req,
   rgpg_rsp_if.source               rsp,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CsrAddrWidth-1:0]  csr_paddr,
   input  logic [CsrDataWidth-1:0]  csr_pwdata,
   output logic [CsrDataWidth-1:0]  csr_prdata,
   output logic                     csr_pready
);
   localparam int DW      = $clog2(MaxDim + 1);
   localparam int D2Width = 2 * DW + 1;
   localparam int TagWidth = 1 + 24;
   localparam int NCells  = FracBits + 1;
   localparam int SqWidth  = 2 * (FracBits + 1) + D2Width;
   localparam int LinWidth = FracBits + 1 + D2Width;

   logic [12:0] width_ff, height_ff;
   logic [7:0]  sr_ff, sg_ff, sb_ff, er_ff, eg_ff, eb_ff;
   reg_index_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd100;
         height_ff <= 13'd100;
         sr_ff <= 8'hff; sg_ff <= 8'hff; sb_ff <= 8'hff;
         er_ff <= 8'h00; eg_ff <= 8'h00; eb_ff <= 8'h00;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_idx)
            REG_IMAGE_WIDTH:  width_ff  <= csr_pwdata[12:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[12:0];
            REG_START_RED:    sr_ff <= csr_pwdata[7:0];
            REG_START_GREEN:  sg_ff <= csr_pwdata[7:0];
            REG_START_BLUE:   sb_ff <= csr_pwdata[7:0];
            REG_END_RED:      er_ff <= csr_pwdata[7:0];
            REG_END_GREEN:    eg_ff <= csr_pwdata[7:0];
            REG_END_BLUE:     eb_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_IMAGE_WIDTH:  csr_prdata = 32'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = 32'(height_ff);
         REG_START_RED:    csr_prdata = 32'(sr_ff);
         REG_START_GREEN:  csr_prdata = 32'(sg_ff);
         REG_START_BLUE:   csr_prdata = 32'(sb_ff);
         REG_END_RED:      csr_prdata = 32'(er_ff);
         REG_END_GREEN:    csr_prdata = 32'(eg_ff);
         REG_END_BLUE:     csr_prdata = 32'(eb_ff);
         default:          csr_prdata = '0;
      endcase
   end

   logic advance;
   logic out_valid_ff;
   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = advance;

   logic [DW-1:0] w_c, h_c;
   always_comb begin
      if (width_ff == 13'd0)                w_c = DW'(1);
      else if (32'(width_ff) > MaxDim)      w_c = DW'(MaxDim);
      else                                   w_c = DW'(width_ff);
      if (height_ff == 13'd0)               h_c = DW'(1);
      else if (32'(height_ff) > MaxDim)     h_c = DW'(MaxDim);
      else                                   h_c = DW'(height_ff);
   end

   // input stage: squares and index
   logic               s0_valid_ff;
   logic [D2Width-1:0] s0_dist2_ff, s0_diag2_ff;
   logic [TagWidth-1:0] s0_tag_ff;
   logic               oor;
   logic [DW-1:0]      dx;
   logic [2*DW-1:0]    idx_full;

   always_comb begin
      oor      = (DW'(req.pixel_x) >= w_c) || (DW'(req.pixel_y) >= h_c)
                 || (32'(req.pixel_x) >= 32'(w_c)) || (32'(req.pixel_y) >= 32'(h_c));
      dx       = w_c - DW'(req.pixel_x);
      idx_full = (2*DW)'(req.pixel_y) * (2*DW)'(w_c) + (2*DW)'(req.pixel_x);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_dist2_ff <= D2Width'(dx) * D2Width'(dx)
                        + D2Width'(req.pixel_y) * D2Width'(req.pixel_y);
         s0_diag2_ff <= D2Width'(w_c) * D2Width'(w_c) + D2Width'(h_c) * D2Width'(h_c);
         s0_tag_ff   <= {oor, oor ? 24'd0 : 24'(idx_full)};
      end
   end

   logic                valid_c [NCells+1];
   logic [D2Width-1:0]  dist2_c [NCells+1];
   logic [D2Width-1:0]  diag2_c [NCells+1];
   logic [FracBits:0]   p_c     [NCells+1];
   logic [SqWidth-1:0]  sq_c    [NCells+1];
   logic [LinWidth-1:0] lin_c   [NCells+1];
   logic [TagWidth-1:0] tag_c   [NCells+1];

   assign valid_c[0] = s0_valid_ff;
   assign dist2_c[0] = s0_dist2_ff;
   assign diag2_c[0] = s0_diag2_ff;
   assign p_c[0]     = '0;
   assign sq_c[0]    = '0;
   assign lin_c[0]   = '0;
   assign tag_c[0]   = s0_tag_ff;

   for (genvar i = 0; i < NCells; i++) begin : g_cell
      rgpg_sqrt_cell #(
         .FracBits(FracBits), .Bit(FracBits - i),
         .D2Width(D2Width), .TagWidth(TagWidth)
      ) u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .valid_in(valid_c[i]), .dist2_in(dist2_c[i]), .diag2_in(diag2_c[i]),
         .p_in(p_c[i]), .sq_in(sq_c[i]), .lin_in(lin_c[i]), .tag_in(tag_c[i]),
         .valid_out(valid_c[i+1]), .dist2_out(dist2_c[i+1]),
         .diag2_out(diag2_c[i+1]), .p_out(p_c[i+1]), .sq_out(sq_c[i+1]),
         .lin_out(lin_c[i+1]), .tag_out(tag_c[i+1])
      );
   end

   // blend stage: products registered, then sum and shift at output
   localparam int BW = FracBits + 10;
   logic [FracBits:0] p_last, q;
   logic [BW-1:0] r_a_ff, r_b_ff, g_a_ff, g_b_ff, b_a_ff, b_b_ff;
   logic          bl_valid_ff;
   logic [TagWidth-1:0] bl_tag_ff;

   assign p_last = p_c[NCells];
   assign q      = ((FracBits+1)'(1) << FracBits) - p_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         bl_valid_ff <= 1'b0;
      end else if (advance) begin
         bl_valid_ff <= valid_c[NCells];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r_a_ff <= BW'(q) * BW'(sr_ff);  r_b_ff <= BW'(p_last) * BW'(er_ff);
         g_a_ff <= BW'(q) * BW'(sg_ff);  g_b_ff <= BW'(p_last) * BW'(eg_ff);
         b_a_ff <= BW'(q) * BW'(sb_ff);  b_b_ff <= BW'(p_last) * BW'(eb_ff);
         bl_tag_ff <= tag_c[NCells];
      end
   end

   logic [BW-1:0] r_s, g_s, b_s;
   assign r_s = (r_a_ff + r_b_ff) >> FracBits;
   assign g_s = (g_a_ff + g_b_ff) >> FracBits;
   assign b_s = (b_a_ff + b_b_ff) >> FracBits;

   logic [23:0] word_ff, index_ff;
   logic        oor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= bl_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         oor_ff   <= bl_tag_ff[24];
         index_ff <= bl_tag_ff[23:0];
         word_ff  <= bl_tag_ff[24] ? 24'd0 : {r_s[7:0], g_s[7:0], b_s[7:0]};
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.pixel_word   = word_ff;
   assign rsp.buffer_index = index_ff;
   assign rsp.out_of_range = oor_ff;
endmodule

// ===== sv/rgpg_checker.sv =====
module rgpg_checker
   import rgpg_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [23:0] rsp_pixel_word,
   input logic [23:0] rsp_buffer_index,
   input logic        rsp_out_of_range,
   input logic        csr_pready
);
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_pixel_word == 24'd0 && rsp_buffer_index == 24'd0)
      else $error("out of range result not zeroed");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   a_stall_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken during output stall");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_word))
      else $error("stalled result changed");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");
endmodule

bind radial_gradient_pixel_generator_core rgpg_checker u_rgpg_checker (
   .clock(clock), .reset(reset),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_pixel_word(rsp.pixel_word), .rsp_buffer_index(rsp.buffer_index),
   .rsp_out_of_range(rsp.out_of_range), .csr_pready(csr_pready)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import rgpg_pkg::*;

   localparam int MaxDim = 4096;
   localparam int FracBits = 16;
   localparam int Latency = FracBits + 4;
   localparam longint CycleLimit = 400000;

   typedef struct packed {
      logic [23:0] pixel_word;
      logic [23:0] buffer_index;
      logic        out_of_range;
   } pixel_result_type;

   class gradient_scoreboard;
      logic [12:0] width_reg = 13'd100;
      logic [12:0] height_reg = 13'd100;
      logic [7:0] start_color [3] = '{8'd255, 8'd255, 8'd255};
      logic [7:0] end_color [3] = '{8'd0, 8'd0, 8'd0};
      pixel_result_type pending_pixels[$];
      int errors = 0;

      function longint unsigned clamp_size(logic [12:0] v);
         if (v == 0) return 1;
         if (v > MaxDim) return MaxDim;
         return v;
      endfunction

      function void set_register(reg_index_type idx, logic [31:0] value);
         case (idx)
            REG_IMAGE_WIDTH: width_reg = value[12:0];
            REG_IMAGE_HEIGHT: height_reg = value[12:0];
            REG_START_RED: start_color[0] = value[7:0];
            REG_START_GREEN: start_color[1] = value[7:0];
            REG_START_BLUE: start_color[2] = value[7:0];
            REG_END_RED: end_color[0] = value[7:0];
            REG_END_GREEN: end_color[1] = value[7:0];
            REG_END_BLUE: end_color[2] = value[7:0];
            default: ;
         endcase
      endfunction

      function void note_pixel(logic [11:0] x, logic [11:0] y);
         longint unsigned w, h, dx, dist2, diag2, p, cand;
         logic [127:0] lhs, rhs;
         logic [15:0] mix [3];
         pixel_result_type res;
         w = clamp_size(width_reg);
         h = clamp_size(height_reg);
         res = '0;
         if (x >= w || y >= h) begin
            res.out_of_range = 1'b1;
         end else begin
            dx = w - x;
            dist2 = dx * dx + longint'(y) * y;
            diag2 = w * w + h * h;
            rhs = 128'(dist2) << (2 * FracBits);
            p = 0;
            for (int b = FracBits; b >= 0; b--) begin
               cand = p | (64'd1 << b);
               lhs = 128'(cand * cand) * 128'(diag2);
               if (lhs <= rhs) p = cand;
            end
            for (int c = 0; c < 3; c++)
               mix[c] = 16'((((64'd1 << FracBits) - p) * start_color[c]
                             + p * end_color[c]) >> FracBits);
            res.pixel_word = {mix[0][7:0], mix[1][7:0], mix[2][7:0]};
            res.buffer_index = 24'(longint'(y) * w + x);
         end
         pending_pixels.push_back(res);
      endfunction

      function void check_pixel(pixel_result_type got);
         pixel_result_type want;
         if (pending_pixels.size() == 0) begin
            $error("unexpected transaction %h", got);
            errors++;
            return;
         end
         want = pending_pixels.pop_front();
         if (got.pixel_word !== want.pixel_word) begin
            $error("pixel_word expected %h actual %h", want.pixel_word, got.pixel_word);
            errors++;
         end
         if (got.buffer_index !== want.buffer_index) begin
            $error("buffer_index expected %h actual %h", want.buffer_index,
                   got.buffer_index);
            errors++;
         end
         if (got.out_of_range !== want.out_of_range) begin
            $error("out_of_range expected %b actual %b", want.out_of_range,
                   got.out_of_range);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [CsrDataWidth-1:0] csr_pwdata, csr_prdata;
   logic csr_pready;
   longint cycle_count = 0;
   bit stall_mode = 0;

   rgpg_req_if req ();
   rgpg_rsp_if rsp ();

   gradient_scoreboard pixel_board = new();

   radial_gradient_pixel_generator_core DUT (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("[radial_gradient_pixel_generator_core] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         pixel_board.check_pixel({rsp.pixel_word, rsp.buffer_index, rsp.out_of_range});
      if (reset) rsp.ready <= 1'b0;
      else if (stall_mode) rsp.ready <= ($urandom_range(0, 3) != 0);
      else rsp.ready <= (cycle_count % 7 < 4) || ($urandom_range(0, 1) == 1);
   end

   always @(posedge clock)
      if (req.valid && req.ready && !reset)
         pixel_board.note_pixel(req.pixel_x, req.pixel_y);

   task automatic write_register(reg_index_type idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CsrAddrWidth'(4 * idx);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      pixel_board.set_register(idx, value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic send_pixel(logic [11:0] x, logic [11:0] y);
      req.valid <= 1'b1;
      req.pixel_x <= x;
      req.pixel_y <= y;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic hold_sender();
      req.valid <= 1'b0;
   endtask

   task automatic drain_results();
      hold_sender();
      @(posedge clock);
      while (pixel_board.pending_pixels.size() != 0) @(posedge clock);
      repeat (Latency + 2) @(posedge clock);
   endtask

   task automatic set_gradient(logic [12:0] w, logic [12:0] h,
                               logic [7:0] sr, logic [7:0] sg, logic [7:0] sb,
                               logic [7:0] er, logic [7:0] eg, logic [7:0] eb);
      drain_results();
      write_register(REG_IMAGE_WIDTH, 32'(w));
      write_register(REG_IMAGE_HEIGHT, 32'(h));
      write_register(REG_START_RED, 32'(sr));
      write_register(REG_START_GREEN, 32'(sg));
      write_register(REG_START_BLUE, 32'(sb));
      write_register(REG_END_RED, 32'(er));
      write_register(REG_END_GREEN, 32'(eg));
      write_register(REG_END_BLUE, 32'(eb));
   endtask

   task automatic random_pixels(int count, int wide);
      int burst;
      logic [11:0] x, y;
      int sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && sent < count; i++) begin
            if ($urandom_range(0, 9) < wide) begin
               x = 12'($urandom);
               y = 12'($urandom);
            end else begin
               x = 12'($urandom_range(0,
                      32'(pixel_board.clamp_size(pixel_board.width_reg) - 1)));
               y = 12'($urandom_range(0,
                      32'(pixel_board.clamp_size(pixel_board.height_reg) - 1)));
            end
            send_pixel(x, y);
            sent++;
         end
         if ($urandom_range(0, 2) != 0) begin
            hold_sender();
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req.valid = 1'b0;
      req.pixel_x = '0;
      req.pixel_y = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_pixel(12'd0, 12'd0);
      send_pixel(12'd99, 12'd99);
      send_pixel(12'd100, 12'd0);
      send_pixel(12'd0, 12'd100);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd50, 12'd50);
      set_gradient(13'd4096, 13'd4096, 8'd0, 8'd128, 8'd255, 8'd255, 8'd127, 8'd0);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd0, 12'd4095);
      send_pixel(12'd2730, 12'd1365);
      set_gradient(13'd0, 13'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd1, 12'd0);
      set_gradient(13'h1FFF, 13'd5000, 8'd17, 8'd34, 8'd51, 8'd200, 8'd100, 8'd50);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd1234, 12'd3210);
      set_gradient(13'd1, 13'd4096, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      send_pixel(12'd0, 12'd4095);
      send_pixel(12'd1, 12'd5);

      for (int phase = 0; phase < 8; phase++) begin
         stall_mode = phase[0];
         if (phase == 7)
            set_gradient(13'd100, 13'd100, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
         else
            set_gradient(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
                         8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom), 8'($urandom));
         random_pixels(150, phase == 3 ? 10 : 2);
      end

      drain_results();
      if (pixel_board.errors == 0 && pixel_board.pending_pixels.size() == 0)
         $display("[radial_gradient_pixel_generator_core] OK");
      else
         $display("[radial_gradient_pixel_generator_core] ERROR");
      $finish;
   end
endmodule
